/* rtl/aes128_pkg.sv */
// AES-128 package: S-box tables, round functions and key schedule step.
package aes128_pkg;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1
   } csr_index_type;

   localparam int Rounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   localparam byte_type SBOX_FWD [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam byte_type SBOX_INV [256] = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
   };

   function automatic byte_type gf2(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // state byte n sits at bits 127-8n downto 120-8n
   function automatic byte_type get_b(input block_type s, input int n);
      return s[127 - 8 * n -: 8];
   endfunction

   function automatic block_type mix_cols(input block_type s, input logic inv);
      block_type o;
      byte_type  a [4];
      byte_type  all, u, v;
      o = s;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) a[i] = get_b(s, 4 * c + i);
         if (inv) begin
            u = gf2(gf2(a[0] ^ a[2]));
            v = gf2(gf2(a[1] ^ a[3]));
            a[0] = a[0] ^ u;
            a[1] = a[1] ^ v;
            a[2] = a[2] ^ u;
            a[3] = a[3] ^ v;
         end
         all = a[0] ^ a[1] ^ a[2] ^ a[3];
         for (int i = 0; i < 4; i++)
            o[127 - 8 * (4 * c + i) -: 8] = a[i] ^ all ^ gf2(a[i] ^ a[(i + 1) % 4]);
      end
      return o;
   endfunction

   function automatic block_type enc_round(input block_type s, input block_type k,
                                           input logic last);
      block_type o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            o[127 - 8 * (r + 4 * c) -: 8] = SBOX_FWD[get_b(s, r + 4 * ((c + r) % 4))];
      if (!last) o = mix_cols(o, 1'b0);
      return o ^ k;
   endfunction

   function automatic block_type dec_round(input block_type s, input block_type k,
                                           input logic last);
      block_type o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = SBOX_INV[get_b(s, r + 4 * c)];
      o = o ^ k;
      if (!last) o = mix_cols(o, 1'b1);
      return o;
   endfunction

   function automatic block_type key_step(input block_type k, input byte_type rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX_FWD[w3[23:16]] ^ rcon, SBOX_FWD[w3[15:8]], SBOX_FWD[w3[7:0]],
           SBOX_FWD[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

/* rtl/aes128_block_cipher.sv */
// AES-128 block cipher: key schedule sequencer and eleven-stage round pipeline.
//
// req_* carries one block per item (req_tuser 0 encrypt, 1 decrypt); rsp_*
// returns the processed block. Key is written through csr_* (index 0 key
// bytes 0..7, index 1 key bytes 8..15); the user writes it only while no item
// is in flight; the block does not enforce this. Each result passes the initial
// key add register and one register per round. Throughput: one item per cycle
// unless a low rsp_tready or key expansion stalls it; every round has its own
// pipeline stage, with valid bits traveling alongside. Key expansion: after
// reset and after every key write the sequencer builds round keys 1..10 one per
// cycle; req_tready is low while it runs. Reset (synchronous) zeroes the key,
// empties the pipeline and starts the expansion of the all-zero key.
// Stall: each full stage holds while the one after it is full and stalled, so
// bubbles close up and the pipeline keeps taking items until it is full.
module aes128_block_cipher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_low, block_high
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_low, result_high
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import aes128_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   block_type   rk_ff [Rounds + 1];
   block_type   last_ff;
   logic [7:0]  rcon_ff;
   logic [3:0]  step_ff;
   logic        busy_ff;

   block_type   data_ff [Rounds + 1];
   logic        act_ff  [Rounds + 1];
   logic [Rounds:0] vld_ff;
   block_type   st_in   [Rounds + 1];
   logic [Rounds:0] rdy;
   block_type   exp_in;
   logic        key_wr;
   block_type   new_key;

   assign exp_in = key_step(last_ff, rcon_ff);
   assign key_wr = csr_wen && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);
   assign new_key = (csr_index == CSR_KEY_HIGH) ? {csr_wdata, key_low_ff}
                                                : {key_high_ff, csr_wdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         rk_ff[0]    <= '0;
         last_ff     <= '0;
         rcon_ff     <= 8'h01;
         step_ff     <= 4'd1;
         busy_ff     <= 1'b1;
      end else if (key_wr) begin
         if (csr_index == CSR_KEY_HIGH) key_high_ff <= csr_wdata;
         else key_low_ff <= csr_wdata;
         rk_ff[0] <= new_key;
         last_ff  <= new_key;
         rcon_ff  <= 8'h01;
         step_ff  <= 4'd1;
         busy_ff  <= 1'b1;
      end else if (busy_ff) begin
         rk_ff[step_ff] <= exp_in;
         last_ff        <= exp_in;
         rcon_ff        <= gf2(rcon_ff);
         step_ff        <= step_ff + 4'd1;
         if (step_ff == 4'(Rounds)) busy_ff <= 1'b0;
      end
   end

   always_comb begin
      rdy[Rounds] = !vld_ff[Rounds] || rsp_tready;
      for (int k = Rounds - 1; k >= 0; k--) rdy[k] = !vld_ff[k] || rdy[k + 1];
      st_in[0] = {req_tdata[63:0], req_tdata[127:64]} ^ (req_tuser ? rk_ff[Rounds] : rk_ff[0]);
      for (int k = 1; k <= Rounds; k++)
         st_in[k] = act_ff[k - 1]
                    ? dec_round(data_ff[k - 1], rk_ff[Rounds - k], k == Rounds)
                    : enc_round(data_ff[k - 1], rk_ff[k], k == Rounds);
   end

   assign req_tready = rdy[0] && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid && req_tready;
         for (int k = 1; k <= Rounds; k++)
            if (rdy[k]) vld_ff[k] <= vld_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         data_ff[0] <= st_in[0];
         act_ff[0]  <= req_tuser;
      end
      for (int k = 1; k <= Rounds; k++)
         if (rdy[k]) begin
            data_ff[k] <= st_in[k];
            act_ff[k]  <= act_ff[k - 1];
         end
   end

   assign rsp_tvalid = vld_ff[Rounds];
   assign rsp_tdata  = {data_ff[Rounds][63:0], data_ff[Rounds][127:64]};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("item accepted during key expansion");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff >= 4'd1 && step_ff <= 4'(Rounds)))
      else $error("key step out of range");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[Rounds] && !rsp_tready) |=> (vld_ff[Rounds] && $stable(rsp_tdata)))
      else $error("stalled result lost");
   a_expand_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == 4'(Rounds) && !key_wr) |=> !busy_ff)
      else $error("expansion did not finish");

endmodule

/* sim/aes128_block_cipher_tb.sv */
// Self-checking testbench for the AES-128 block cipher pipeline (encrypt and decrypt).
module aes128_block_cipher_tb;
   import aes128_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       ActEncrypt     = 1'b0;
   localparam logic       ActDecrypt     = 1'b1;
   localparam logic [1:0] CsrUnusedIndex = 2'd2;
   localparam logic [1:0] CsrLastIndex   = 2'd3;
   localparam int         CycleLimit     = 400000;

   typedef struct packed {
      logic        action;
      logic [63:0] blk_high;
      logic [63:0] blk_low;
   } cipher_req_type;

   typedef struct packed {
      logic [63:0] res_high;
      logic [63:0] res_low;
   } cipher_res_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // block_low, block_high
   logic         req_tuser = 1'b0;   // action
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;   // result_low, result_high
   logic         csr_wen;
   logic [1:0]   csr_index;
   logic [63:0]  csr_wdata;

   aes128_block_cipher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cipher_req_type pending_blocks [$];
   cipher_res_type expected_blocks [$];
   logic [7:0]   sbox_f [256];
   logic [7:0]   sbox_i [256];
   logic [63:0]  key_hi_q, key_lo_q;
   logic [127:0] sched_key [11];
   int           mismatches = 0;
   int           cycle_count = 0;
   logic         item_accepted = 1'b0;
   int           burst_left = 5;
   int           gap_left = 0;
   int           hold_left = 0;
   int           rx_mode = 0;
   int           rx_count = 0;
   logic         long_hold_start;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p, x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      return p;
   endfunction

   // S-boxes from the field inverse and the affine map
   task automatic build_sboxes();
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (x != 0 && gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sbox_f[x] = b;
         sbox_i[b] = x[7:0];
      end
   endtask

   task automatic expand_key();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      w[0] = key_hi_q[63:32];
      w[1] = key_hi_q[31:0];
      w[2] = key_lo_q[63:32];
      w[3] = key_lo_q[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_f[t[31:24]] ^ rc, sbox_f[t[23:16]], sbox_f[t[15:8]], sbox_f[t[7:0]]};
            rc = xtime(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++)
         sched_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endtask

   function automatic cipher_res_type aes_transform(input cipher_req_type rq);
      logic [7:0]  s [16];
      logic [7:0]  t [16];
      logic [7:0]  a [4];
      logic [7:0]  all, u, v;
      logic [127:0] blk;
      cipher_res_type res;
      blk = {rq.blk_high, rq.blk_low};
      for (int n = 0; n < 16; n++) s[n] = blk[127-8*n -: 8];
      for (int step = 0; step < 11; step++) begin
         int rk;
         rk = (rq.action == ActEncrypt) ? step : 10 - step;
         if (rq.action == ActEncrypt && step > 0) begin
            for (int n = 0; n < 16; n++) t[n] = sbox_f[s[n]];
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) s[r+4*c] = t[r+4*((c+r)%4)];
            if (step < 10)
               for (int c = 0; c < 4; c++) begin
                  for (int i = 0; i < 4; i++) a[i] = s[4*c+i];
                  all = a[0] ^ a[1] ^ a[2] ^ a[3];
                  for (int i = 0; i < 4; i++)
                     s[4*c+i] = a[i] ^ all ^ xtime(a[i] ^ a[(i+1)%4]);
               end
         end
         if (rq.action == ActDecrypt && step > 0) begin
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) t[r+4*((c+r)%4)] = s[r+4*c];
            for (int n = 0; n < 16; n++) s[n] = sbox_i[t[n]];
         end
         for (int n = 0; n < 16; n++) s[n] = s[n] ^ sched_key[rk][127-8*n -: 8];
         if (rq.action == ActDecrypt && step > 0 && step < 10)
            for (int c = 0; c < 4; c++) begin
               for (int i = 0; i < 4; i++) a[i] = s[4*c+i];
               u = xtime(xtime(a[0] ^ a[2]));
               v = xtime(xtime(a[1] ^ a[3]));
               a[0] = a[0] ^ u;
               a[1] = a[1] ^ v;
               a[2] = a[2] ^ u;
               a[3] = a[3] ^ v;
               all = a[0] ^ a[1] ^ a[2] ^ a[3];
               for (int i = 0; i < 4; i++)
                  s[4*c+i] = a[i] ^ all ^ xtime(a[i] ^ a[(i+1)%4]);
            end
      end
      for (int n = 0; n < 16; n++) blk[127-8*n -: 8] = s[n];
      res.res_high = blk[127:64];
      res.res_low  = blk[63:0];
      return res;
   endfunction

   // input side: bursts with random gaps
   always @(negedge clock) begin
      if (item_accepted) begin
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
      if (gap_left > 0 && !(item_accepted && burst_left <= 1)) begin
         gap_left   <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_blocks.size() > 0 && !(item_accepted && burst_left <= 1)) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {pending_blocks[0].blk_low, pending_blocks[0].blk_high};
         req_tuser  <= pending_blocks[0].action;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // output side: stall pattern plus one long hold-off on request
   always @(negedge clock) begin
      rx_count <= rx_count + 1;
      if (rx_count % 37 == 0) rx_mode <= $urandom_range(0, 2);
      if (long_hold_start) begin
         hold_left  <= 90;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if (rx_mode == 1) begin
         rsp_tready <= 1'($urandom_range(0, 1));
      end else begin
         rsp_tready <= (rx_count % 5 == 0);
      end
   end

   always @(posedge clock) begin
      cipher_res_type got, want;
      cycle_count   <= cycle_count + 1;
      item_accepted <= !reset && req_tvalid && req_tready;
      if (cycle_count > CycleLimit) begin
         $display("[aes128_block_cipher] ERROR");
         $finish;
      end else begin
         if (!reset && req_tvalid && req_tready)
            expected_blocks = {expected_blocks, aes_transform(pending_blocks.pop_front())};
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.res_high = rsp_tdata[63:0];
            got.res_low  = rsp_tdata[127:64];
            if (expected_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item %h %h", got.res_high, got.res_low);
            end else begin
               want = expected_blocks.pop_front();
               if (got.res_high !== want.res_high || got.res_low !== want.res_low) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h got %h %h", want.res_high,
                              want.res_low, got.res_high, got.res_low);
               end
            end
         end
      end
   end

   task automatic queue_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
      cipher_req_type rq;
      rq.action   = act;
      rq.blk_high = hi;
      rq.blk_low  = lo;
      pending_blocks = {pending_blocks, rq};
   endtask

   task automatic wait_drained();
      while (pending_blocks.size() > 0 || expected_blocks.size() > 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_KEY_HIGH) key_hi_q = val;
      else if (idx == CSR_KEY_LOW) key_lo_q = val;
      expand_key();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_blocks(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            queue_block(1'($urandom_range(0, 1)),
                        64'hFFFF_FFFF_FFFF_FFFF ^ rand64() & rand64(),
                        rand64() | rand64());
         else
            queue_block(1'($urandom_range(0, 1)), rand64(), rand64());
      end
   endtask

   initial begin
      cipher_res_type fips_ct;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_wdata = '0;
      long_hold_start = 1'b0;
      key_hi_q = '0;
      key_lo_q = '0;
      build_sboxes();
      expand_key();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: all-zero key after reset
      queue_block(ActEncrypt, 64'h0, 64'h0);
      queue_block(ActDecrypt, 64'h0, 64'h0);
      queue_block(ActEncrypt, '1, '1);
      queue_block(ActDecrypt, '1, '1);
      queue_block(ActEncrypt, 64'h8000_0000_0000_0000, 64'h1);
      queue_block(ActDecrypt, 64'h1, 64'h8000_0000_0000_0000);
      wait_drained();

      // FIPS-197 example key, round trip
      write_csr(CSR_KEY_HIGH, 64'h0001_0203_0405_0607);
      write_csr(CSR_KEY_LOW, 64'h0809_0A0B_0C0D_0E0F);
      fips_ct.res_high = 64'h69C4_E0D8_6A7B_0430;
      fips_ct.res_low  = 64'hD8CD_B780_70B4_C55A;
      queue_block(ActEncrypt, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
      queue_block(ActDecrypt, fips_ct.res_high, fips_ct.res_low);
      queue_block(ActEncrypt, '1, 64'h0);
      queue_block(ActDecrypt, 64'h0, '1);
      wait_drained();

      // all-ones key, ignored writes to unused indexes
      write_csr(CSR_KEY_HIGH, '1);
      write_csr(CSR_KEY_LOW, '1);
      write_csr(CsrUnusedIndex, rand64());
      write_csr(CsrLastIndex, rand64());
      queue_block(ActEncrypt, 64'h0, 64'h0);
      queue_block(ActDecrypt, 64'h0, 64'h0);
      queue_block(ActEncrypt, '1, '1);
      queue_block(ActDecrypt, '1, '1);
      random_blocks(150);
      wait_drained();

      // receiver holds off while blocks keep coming
      write_csr(CSR_KEY_HIGH, rand64());
      write_csr(CSR_KEY_LOW, rand64());
      random_blocks(150);
      @(posedge clock);
      long_hold_start = 1'b1;
      @(posedge clock);
      long_hold_start = 1'b0;
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         write_csr(CSR_KEY_HIGH, rand64());
         write_csr(CSR_KEY_LOW, (ph == 0) ? 64'h0 : rand64());
         random_blocks(150);
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_blocks.size() == 0)
         $display("[aes128_block_cipher] OK");
      else
         $display("[aes128_block_cipher] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/aes128_pkg.sv
rtl/aes128_block_cipher.sv
sim/aes128_block_cipher_tb.sv
